// File: sv/msws_pkg.sv
package msws_pkg;

    // Frame and window limits
    localparam int MAX_ROWS   = 1024;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_WINDOW = 32;   // ring depth, kept a power of two

    // Field widths fixed by the port list
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int WIN_W     = 6;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int SLOT_W    = $clog2(MAX_WINDOW);
    localparam int HIST_AW   = SLOT_W + COL_W;
    localparam int HIST_DEPTH = MAX_WINDOW * MAX_COLS;
    localparam int SUM_W     = 32;    // sums wrap modulo 2^32
    localparam int OUT_SUM_W = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

    // Running sum update modes
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_SLIDE = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] row_slot;
        logic [SLOT_W-1:0] old_slot;
        logic [COL_W-1:0]  back_col;
        logic [1:0]        col_mode;
        logic [1:0]        win_mode;
        logic              eligible;
        logic [ROW_W-1:0]  top;
        logic [COL_W-1:0]  left;
        logic              last;
        logic              clear_best;
    } msws_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } msws_qstat_t;

endpackage

// File: sv/msws_front.sv
module msws_front
    import msws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  msws_qstat_t           qstat,
    output logic                  push,
    output msws_item_t            item
);

    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] row_length_reg;
    logic [WIN_W-1:0] window_size_reg;
    logic [DIM_W-1:0] row_pos_reg;
    logic [DIM_W-1:0] col_pos_reg;
    logic [DIM_W-1:0] row_pos_next;
    logic [DIM_W-1:0] col_pos_next;

    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] ws_ext;
    logic             ws_ok;
    logic             wrap_col;
    logic             over;
    logic [DIM_W-1:0] row_adv;
    logic [DIM_W-1:0] col_adv;
    logic [DIM_W-1:0] r_full;
    logic [DIM_W-1:0] c_full;
    logic [DIM_W-1:0] r1;
    logic [DIM_W-1:0] c1;
    logic [DIM_W-1:0] top_full;
    logic [DIM_W-1:0] left_full;
    logic [DIM_W-1:0] old_full;
    logic [DIM_W-1:0] back_full;
    logic             last;

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= DIM_W'(MAX_ROWS);
            row_length_reg  <= DIM_W'(MAX_COLS);
            window_size_reg <= WIN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:    num_rows_reg    <= cfg_data;
                REG_ROW_LENGTH:  row_length_reg  <= cfg_data;
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        rows = num_rows_reg;
        if (num_rows_reg == '0)
            rows = DIM_W'(1);
        else if (num_rows_reg > DIM_W'(MAX_ROWS))
            rows = DIM_W'(MAX_ROWS);

        cols = row_length_reg;
        if (row_length_reg == '0)
            cols = DIM_W'(1);
        else if (row_length_reg > DIM_W'(MAX_COLS))
            cols = DIM_W'(MAX_COLS);

        ws_ext = DIM_W'(window_size_reg);
        ws_ok  = (window_size_reg != '0) && (window_size_reg <= WIN_W'(MAX_WINDOW));

        // wrap to the next row, then to a new frame if the rows ran out
        wrap_col = col_pos_reg >= cols;
        row_adv  = wrap_col ? row_pos_reg + DIM_W'(1) : row_pos_reg;
        col_adv  = wrap_col ? '0 : col_pos_reg;
        over     = row_adv >= rows;
        r_full   = over ? '0 : row_adv;
        c_full   = over ? '0 : col_adv;

        r1        = r_full + DIM_W'(1);
        c1        = c_full + DIM_W'(1);
        last      = (r1 >= rows) && (c1 >= cols);
        top_full  = r1 - ws_ext;
        left_full = c1 - ws_ext;
        old_full  = r_full - ws_ext;
        back_full = c_full - ws_ext;

        item.pixel      = pixel;
        item.col        = c_full[COL_W-1:0];
        item.row_slot   = r_full[SLOT_W-1:0];
        item.old_slot   = old_full[SLOT_W-1:0];
        item.back_col   = back_full[COL_W-1:0];
        item.eligible   = ws_ok && (r1 >= ws_ext) && (c1 >= ws_ext);
        item.top        = top_full[ROW_W-1:0];
        item.left       = left_full[COL_W-1:0];
        item.last       = last;
        item.clear_best = over;

        if (r_full == '0)
            item.col_mode = MODE_SET;
        else if (!ws_ok || (r_full < ws_ext))
            item.col_mode = MODE_ADD;
        else
            item.col_mode = MODE_SLIDE;

        if (c_full == '0)
            item.win_mode = MODE_SET;
        else if (!ws_ok || (c_full < ws_ext))
            item.win_mode = MODE_ADD;
        else
            item.win_mode = MODE_SLIDE;

        row_pos_next = last ? '0 : r_full;
        col_pos_next = last ? '0 : c1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (push)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

endmodule

// File: sv/msws_queue.sv
module msws_queue
    import msws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  msws_item_t  item_in,
    input  logic        pop,
    output msws_item_t  item_out,
    output msws_qstat_t qstat
);

    msws_item_t         entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign item_out    = entries[rd_ptr_reg];
    assign qstat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= item_in;
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/msws_back.sv
module msws_back
    import msws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  msws_item_t           head,
    input  msws_qstat_t          qstat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ROW_W-1:0]     best_row,
    output logic [COL_W-1:0]     best_col,
    output logic [OUT_SUM_W-1:0] best_sum,
    output logic                 found
);

    logic [PIX_W-1:0] hist_mem [HIST_DEPTH];
    logic [SUM_W-1:0] col_mem  [MAX_COLS];

    logic [SUM_W-1:0] cs_a_rd_reg;
    logic [SUM_W-1:0] cs_b_rd_reg;
    logic [PIX_W-1:0] hist_rd_reg;

    logic             s1_valid_reg;
    msws_item_t       s1_reg;
    logic             s2_valid_reg;
    msws_item_t       s2_reg;
    logic [SUM_W-1:0] s2_cs_reg;
    logic [SUM_W-1:0] s2_csb_reg;
    logic             s3_valid_reg;
    msws_item_t       s3_reg;

    logic [SUM_W-1:0] wsum_reg;
    logic [SUM_W-1:0] wsum_next;
    logic [SUM_W-1:0] best_val_reg;
    logic [ROW_W-1:0] best_top_reg;
    logic [COL_W-1:0] best_left_reg;
    logic             any_reg;

    logic                 out_valid_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [OUT_SUM_W-1:0] out_sum_reg;
    logic                 out_found_reg;

    logic             pend;
    logic [SUM_W-1:0] cs_base;
    logic [SUM_W-1:0] cs_back;
    logic [PIX_W-1:0] old_pix;
    logic [SUM_W-1:0] pix_ext;
    logic [SUM_W-1:0] old_ext;
    logic [SUM_W-1:0] cs_new;

    logic             base_any;
    logic [SUM_W-1:0] base_val;
    logic [ROW_W-1:0] base_top;
    logic [COL_W-1:0] base_left;
    logic             take;
    logic             new_any;
    logic [SUM_W-1:0] new_val;
    logic [ROW_W-1:0] new_top;
    logic [COL_W-1:0] new_left;

    // A frame's last pixel waits until no other result is on its way out
    assign pend = (s1_valid_reg && s1_reg.last) || (s2_valid_reg && s2_reg.last)
                || (s3_valid_reg && s3_reg.last) || out_valid_reg;
    assign pop  = !qstat.empty && (!head.last || !pend);

    // Issue: read both column sums and the pixel leaving the window
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cs_a_rd_reg <= col_mem[head.col];
            cs_b_rd_reg <= col_mem[head.back_col];
        end
        if (s1_valid_reg)
            col_mem[s1_reg.col] <= cs_new;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            hist_rd_reg <= hist_mem[{head.old_slot, head.col}];
        if (s1_valid_reg)
            hist_mem[{s1_reg.row_slot, s1_reg.col}] <= s1_reg.pixel;
    end

    // Column update; forward the previous item's write, which lands on the read edge
    always_comb
    begin
        cs_base = (s2_valid_reg && (s2_reg.col == s1_reg.col)) ? s2_cs_reg : cs_a_rd_reg;
        cs_back = (s2_valid_reg && (s2_reg.col == s1_reg.back_col)) ? s2_cs_reg : cs_b_rd_reg;
        old_pix = (s2_valid_reg && (s2_reg.row_slot == s1_reg.old_slot)
                   && (s2_reg.col == s1_reg.col)) ? s2_reg.pixel : hist_rd_reg;
        pix_ext = SUM_W'(s1_reg.pixel);
        old_ext = SUM_W'(old_pix);

        case (s1_reg.col_mode)
            MODE_SET:   cs_new = pix_ext;
            MODE_ADD:   cs_new = cs_base + pix_ext;
            MODE_SLIDE: cs_new = cs_base + pix_ext - old_ext;
            default:    cs_new = cs_base;
        endcase
    end

    // Window update
    always_comb
    begin
        case (s2_reg.win_mode)
            MODE_SET:   wsum_next = s2_cs_reg;
            MODE_ADD:   wsum_next = wsum_reg + s2_cs_reg;
            MODE_SLIDE: wsum_next = wsum_reg + s2_cs_reg - s2_csb_reg;
            default:    wsum_next = wsum_reg;
        endcase
    end

    // Best window compare; a new frame starts from cleared state
    always_comb
    begin
        base_any  = s3_reg.clear_best ? 1'b0 : any_reg;
        base_val  = s3_reg.clear_best ? '0 : best_val_reg;
        base_top  = s3_reg.clear_best ? '0 : best_top_reg;
        base_left = s3_reg.clear_best ? '0 : best_left_reg;
        take      = s3_reg.eligible && (!base_any || (wsum_reg > base_val));
        new_any   = base_any || take;
        new_val   = take ? wsum_reg : base_val;
        new_top   = take ? s3_reg.top : base_top;
        new_left  = take ? s3_reg.left : base_left;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= head;
        if (s1_valid_reg)
        begin
            s2_reg     <= s1_reg;
            s2_cs_reg  <= cs_new;
            s2_csb_reg <= cs_back;
        end
        if (s2_valid_reg)
            s3_reg <= s2_reg;
        if (s3_valid_reg && s3_reg.last)
        begin
            out_row_reg   <= new_top;
            out_col_reg   <= new_left;
            out_sum_reg   <= new_val[OUT_SUM_W-1:0];
            out_found_reg <= new_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            wsum_reg      <= '0;
            best_val_reg  <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
                wsum_reg <= wsum_next;

            if (s3_valid_reg)
            begin
                if (s3_reg.last)
                begin
                    // drop the frame's best state once the result is out
                    best_val_reg  <= '0;
                    best_top_reg  <= '0;
                    best_left_reg <= '0;
                    any_reg       <= 1'b0;
                end
                else
                begin
                    best_val_reg  <= new_val;
                    best_top_reg  <= new_top;
                    best_left_reg <= new_left;
                    any_reg       <= new_any;
                end
            end

            if (s3_valid_reg && s3_reg.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_row  = out_row_reg;
    assign best_col  = out_col_reg;
    assign best_sum  = out_sum_reg;
    assign found     = out_found_reg;

endmodule

// File: sv/max_square_window_sum_core.sv
// Finds the window_size by window_size square of largest pixel sum in a raster-scanned frame of
// 8-bit pixels and gives its top-left row, column and sum (found = 0 if no square fits) one
// transfer per frame. Pixels are taken at one per cycle while the four-entry queue has room: a
// front stage tracks the position and classifies each pixel into the queue, and a back pipeline
// (memory read, column-sum update, window-sum update, best compare) works one pixel per cycle
// unless it holds back a frame's last pixel. The last pixel of a frame is held at the head of
// the queue until the previous frame's result has been transferred, so frames of a single pixel
// do not overlap in the back pipeline. A 32-row pixel ring (32 x 1024 x 8 bits) and a 1024-entry
// column-sum memory hold no reset contents and need no clearing pass; configuration is to be
// written only while no pixel is in flight, which the block itself does not enforce.
module max_square_window_sum_core
    import msws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROW_W-1:0]      best_row,
    output logic [COL_W-1:0]      best_col,
    output logic [OUT_SUM_W-1:0]  best_sum,
    output logic                  found
);

    msws_qstat_t qstat;
    msws_item_t  front_item;
    msws_item_t  head_item;
    logic        push;
    logic        pop;

    msws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .qstat     (qstat),
        .push      (push),
        .item      (front_item)
    );

    msws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (head_item),
        .qstat    (qstat)
    );

    msws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_item),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .best_row  (best_row),
        .best_col  (best_col),
        .best_sum  (best_sum),
        .found     (found)
    );

endmodule

// File: tb/tb_max_square_window_sum_core.sv
module tb_max_square_window_sum_core;
    import msws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 32;

    typedef enum {PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_FLAT, PAT_PEAKS} pattern_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [OUT_SUM_W-1:0] sum;
        logic                 found;
    } window_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ROW_W-1:0]      best_row;
    logic [COL_W-1:0]      best_col;
    logic [OUT_SUM_W-1:0]  best_sum;
    logic                  found;

    // Register copies and window search state of the predictor
    int unsigned reg_rows = MAX_ROWS;
    int unsigned reg_cols = MAX_COLS;
    int unsigned reg_win  = 1;
    bit [PIX_W-1:0] row_ring [HIST_DEPTH];
    int unsigned    col_total [MAX_COLS];
    int unsigned    win_total;
    int unsigned    pos_row;
    int unsigned    pos_col;
    int unsigned    top_total;
    int unsigned    top_row;
    int unsigned    top_col;
    bit             have_top;

    window_result_t pending_windows[$];
    int unsigned    pixels_sent;
    int unsigned    frames_closed;
    int unsigned    mismatches;
    bit             steady;
    logic [PIX_W-1:0] flat_value;

    max_square_window_sum_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .best_row  (best_row),
        .best_col  (best_col),
        .best_sum  (best_sum),
        .found     (found)
    );

    always #10 clk = ~clk;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned frame_pixels();
        return clamp_dim(reg_rows, MAX_ROWS) * clamp_dim(reg_cols, MAX_COLS);
    endfunction

    function automatic void restart_frame();
        win_total = 0;
        pos_row   = 0;
        pos_col   = 0;
        top_total = 0;
        top_row   = 0;
        top_col   = 0;
        have_top  = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NUM_ROWS:    reg_rows = 32'(data);
            REG_ROW_LENGTH:  reg_cols = 32'(data);
            REG_WINDOW_SIZE: reg_win  = 32'(data[WIN_W-1:0]);
            default: ;
        endcase
    endfunction

    // Advance the window search by one pixel; queue a result at the end of a frame
    function automatic void score_pixel(input logic [PIX_W-1:0] value);
        int unsigned rows;
        int unsigned cols;
        int unsigned ws;
        int unsigned r;
        int unsigned c;
        int unsigned cs;
        int unsigned old;
        bit ws_ok;
        window_result_t res;
        rows  = clamp_dim(reg_rows, MAX_ROWS);
        cols  = clamp_dim(reg_cols, MAX_COLS);
        ws    = reg_win;
        ws_ok = (ws >= 1) && (ws <= MAX_WINDOW);
        if (pos_col >= cols)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= rows)
        begin
            restart_frame();
        end
        r = pos_row;
        c = pos_col;

        // column sum over the last ws rows; read the leaving pixel before overwriting its slot
        if (r == 0)
        begin
            cs = 32'(value);
        end
        else if (!ws_ok || r < ws)
        begin
            cs = col_total[COL_W'(c)] + value;
        end
        else
        begin
            old = 32'(row_ring[HIST_AW'(((r - ws) % MAX_WINDOW) * MAX_COLS + c)]);
            cs  = col_total[COL_W'(c)] + value - old;
        end
        row_ring[HIST_AW'((r % MAX_WINDOW) * MAX_COLS + c)] = value;
        col_total[COL_W'(c)] = cs;

        if (c == 0)
        begin
            win_total = cs;
        end
        else if (!ws_ok || c < ws)
        begin
            win_total = win_total + cs;
        end
        else
        begin
            win_total = win_total + cs - col_total[COL_W'(c - ws)];
        end

        // strict compare keeps the first window in raster order on ties
        if (ws_ok && r + 1 >= ws && c + 1 >= ws)
        begin
            if (!have_top || win_total > top_total)
            begin
                have_top  = 1'b1;
                top_total = win_total;
                top_row   = r + 1 - ws;
                top_col   = c + 1 - ws;
            end
        end
        pos_col = c + 1;

        if (r + 1 >= rows && c + 1 >= cols)
        begin
            if (have_top)
            begin
                res.row   = ROW_W'(top_row);
                res.col   = COL_W'(top_col);
                res.sum   = OUT_SUM_W'(top_total);
                res.found = 1'b1;
            end
            else
            begin
                res = '0;
            end
            pending_windows.push_back(res);
            frames_closed++;
            restart_frame();
        end
    endfunction

    function automatic logic [PIX_W-1:0] make_pixel(input pattern_t pat);
        case (pat)
            PAT_ZERO:  return '0;
            PAT_FULL:  return '1;
            PAT_FLAT:  return flat_value;
            PAT_PEAKS: return ($urandom_range(0, 99) < 5) ? PIX_W'($urandom_range(128, 255))
                                                         : PIX_W'($urandom_range(0, 15));
            default:   return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side stalls at random, about 30 percent of the time, except in the steady stretch
    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end

    always @(posedge clk)
    begin : check_results
        window_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: row %0d col %0d sum %0d found %0b",
                             best_row, best_col, best_sum, found);
                end
            end
            else
            begin
                want = pending_windows.pop_front();
                if (best_row !== want.row || best_col !== want.col ||
                    best_sum !== want.sum || found !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected row %0d col %0d sum %0d found %0b",
                                 want.row, want.col, want.sum, want.found);
                        $display("                 got      row %0d col %0d sum %0d found %0b",
                                 best_row, best_col, best_sum, found);
                    end
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        score_pixel(value);
        pixels_sent++;
    endtask

    // Hold input, let every expected result out, then let the pipeline empty
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic setup(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                         input logic [CFG_DATA_W-1:0] ws);
        drain_block();
        write_reg(REG_NUM_ROWS, rows);
        write_reg(REG_ROW_LENGTH, cols);
        write_reg(REG_WINDOW_SIZE, ws);
    endtask

    task automatic send_frames(input int unsigned count, input pattern_t pat);
        int unsigned n;
        n = frame_pixels();
        repeat (count)
        begin
            flat_value = PIX_W'($urandom_range(0, 255));
            repeat (n) send_pixel(make_pixel(pat));
        end
    endtask

    task automatic test_single_pixel_frames();
        setup(1, 1, 1);
        send_pixel('0);
        send_pixel('1);
        send_frames(2, PAT_RANDOM);
    endtask

    task automatic test_window_too_large();
        setup(2, 3, 3);
        send_frames(1, PAT_RANDOM);
    endtask

    task automatic test_window_out_of_range();
        setup(2, 2, 0);
        send_frames(1, PAT_FULL);
        setup(2, 2, 33);
        send_frames(1, PAT_FULL);
        // upper data bits are dropped, leaving a window of two
        setup(2, 2, 11'h7C2);
        send_frames(1, PAT_FULL);
    endtask

    task automatic test_dim_clamp();
        setup(0, 3, 1);
        send_frames(1, PAT_RANDOM);
        drain_block();
        write_reg(REG_UNUSED, '1);
        send_frames(1, PAT_RANDOM);
        setup(2, 0, 2);
        send_frames(1, PAT_RANDOM);
    endtask

    task automatic test_ties();
        setup(2, 2, 1);
        send_frames(1, PAT_FLAT);
        setup(3, 3, 2);
        send_frames(1, PAT_ZERO);
    endtask

    task automatic test_reconfig_mid_frame();
        // shrink the row past the current column: wrap to the next row
        setup(3, 6, 2);
        repeat (10) send_pixel(make_pixel(PAT_RANDOM));
        drain_block();
        write_reg(REG_ROW_LENGTH, 3);
        repeat (3) send_pixel(make_pixel(PAT_RANDOM));
        // shrink the frame past the current row: restart without a result
        setup(4, 4, 2);
        repeat (6) send_pixel(make_pixel(PAT_RANDOM));
        drain_block();
        write_reg(REG_NUM_ROWS, 1);
        send_frames(1, PAT_RANDOM);
        // grow the window partway through
        setup(4, 4, 1);
        repeat (7) send_pixel(make_pixel(PAT_RANDOM));
        drain_block();
        write_reg(REG_WINDOW_SIZE, 3);
        repeat (9) send_pixel(make_pixel(PAT_RANDOM));
    endtask

    task automatic test_large_frames();
        // saturate the row count, then end the frame once the ring has wrapped
        setup(11'h7FF, 1, 1);
        repeat (40) send_pixel(make_pixel(PAT_PEAKS));
        drain_block();
        write_reg(REG_NUM_ROWS, 41);
        send_pixel(make_pixel(PAT_PEAKS));
        // saturate the row length the same way
        setup(1, 11'h7FF, 1);
        repeat (30) send_pixel(make_pixel(PAT_PEAKS));
        drain_block();
        write_reg(REG_ROW_LENGTH, 31);
        send_pixel(make_pixel(PAT_PEAKS));
        // more rows than the ring holds
        setup(40, 3, 3);
        send_frames(1, PAT_RANDOM);
    endtask

    task automatic test_random_frames();
        int unsigned px_start;
        int unsigned fr_start;
        int unsigned phase;
        int unsigned rows;
        int unsigned cols;
        int unsigned ws;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] ws_data;
        pattern_t pat;
        px_start = pixels_sent;
        fr_start = frames_closed;
        phase    = 0;
        while (pixels_sent - px_start < 480 || frames_closed - fr_start < 30)
        begin
            phase++;
            rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                ws = 0;
            end
            else if (pick == 1)
            begin
                ws = $urandom_range(MAX_WINDOW + 1, 63);
            end
            else if (pick < 5)
            begin
                ws = $urandom_range(5, 8);
            end
            else
            begin
                ws = $urandom_range(1, 4);
            end
            ws_data = CFG_DATA_W'(ws);
            if ($urandom_range(0, 1) == 1)
            begin
                ws_data = ws_data | (CFG_DATA_W'($urandom_range(0, 31)) << WIN_W);
            end
            setup(CFG_DATA_W'(rows), CFG_DATA_W'(cols), ws_data);
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
            end
            steady = (phase >= 4 && phase < 10);
            case ($urandom_range(0, 9))
                0:       pat = PAT_ZERO;
                1:       pat = PAT_FULL;
                2:       pat = PAT_FLAT;
                3, 4:    pat = PAT_PEAKS;
                default: pat = PAT_RANDOM;
            endcase
            send_frames($urandom_range(1, 4), pat);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        restart_frame();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pixel_frames();
        test_window_too_large();
        test_window_out_of_range();
        test_dim_clamp();
        test_ties();
        test_reconfig_mid_frame();
        test_random_frames();
        test_large_frames();
        drain_block();
        if (mismatches == 0 && pending_windows.size() == 0)
        begin
            $display("tb_max_square_window_sum_core OK");
        end
        else
        begin
            $display("tb_max_square_window_sum_core NOT OK");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_max_square_window_sum_core NOT OK");
        $finish;
    end

endmodule
